// File: src/edf_pkg.sv
// Shared types, constants and codes of the earliest-deadline-first priority assigner.
`timescale 1ns / 1ps

package edf_pkg;

	localparam int EDF_MAX_TASKS = 8;
	localparam int EDF_TIME_W    = 32;
	localparam int EDF_DIGIT_W   = 8;

	localparam int OPCODE_W  = 2;
	localparam int TASK_W    = 3;
	localparam int TICKS_W   = 32;
	localparam int PRIO_W    = 4;
	localparam int SLACK_W   = 32;
	localparam int MISS_W    = 16;

	localparam logic [OPCODE_W-1:0] OP_DEFINE  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_START   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_JOB_END = 2'd2;

	localparam logic [MISS_W-1:0] MISS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [TASK_W-1:0]   task_sel;
		logic [TICKS_W-1:0]  now_ticks;
		logic [TICKS_W-1:0]  period_ticks;
	} edf_req_t;

	typedef struct packed {
		logic [TASK_W-1:0]         task_id;
		logic [PRIO_W-1:0]         prio;
		logic signed [SLACK_W-1:0] slack;
		logic                      missed;
		logic [MISS_W-1:0]         miss_total;
		logic                      last;
	} edf_res_t;

	typedef struct packed {
		logic go;
		logic sub;
	} edf_alu_cmd_t;

endpackage

// File: src/edf_req_if.sv
// Request channel interface carrying one scheduling event per transfer.
`timescale 1ns / 1ps

interface edf_req_if;
	logic                valid;
	logic                ready;
	edf_pkg::edf_req_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: src/edf_res_if.sv
// Result channel interface carrying one task priority per transfer.
`timescale 1ns / 1ps

interface edf_res_if;
	logic                valid;
	logic                ready;
	edf_pkg::edf_res_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: src/edf_serial_alu.sv
// Digit-serial adder and subtractor working from the least significant digit upwards.
`timescale 1ns / 1ps

module edf_serial_alu #(
	parameter int TIME_WIDTH = edf_pkg::EDF_TIME_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  edf_pkg::edf_alu_cmd_t  cmd,
	input  logic [TIME_WIDTH-1:0]  a,
	input  logic [TIME_WIDTH-1:0]  b,
	output logic                   done,
	output logic [TIME_WIDTH-1:0]  sum,
	output logic                   carry
);
	import edf_pkg::*;

	localparam int D     = EDF_DIGIT_W;
	localparam int NDIG  = (TIME_WIDTH + EDF_DIGIT_W - 1) / EDF_DIGIT_W;
	localparam int PW    = NDIG * EDF_DIGIT_W;
	localparam int DIG_W = $clog2(NDIG);

	logic [PW-1:0]    a_q;
	logic [PW-1:0]    b_q;
	logic [PW-1:0]    r_q;
	logic             c_q;
	logic             run_q;
	logic             done_q;
	logic [DIG_W-1:0] cnt_q;
	logic [D:0]       dsum;

	assign dsum  = {1'b0, a_q[D-1:0]} + {1'b0, b_q[D-1:0]} + {{D{1'b0}}, c_q};
	assign done  = done_q;
	assign sum   = r_q[TIME_WIDTH-1:0];
	assign carry = c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIG_W'(1);
				if (cnt_q == DIG_W'(NDIG - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Subtraction adds the inverted subtrahend with an initial carry of one.
	always_ff @(posedge clk) begin
		if (cmd.go) begin
			a_q <= PW'(a);
			b_q <= cmd.sub ? ~(PW'(b)) : PW'(b);
			c_q <= cmd.sub;
		end else if (run_q) begin
			a_q <= a_q >> D;
			b_q <= b_q >> D;
			r_q <= {dsum[D-1:0], r_q[PW-1:D]};
			c_q <= dsum[D];
		end
	end

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> !run_q)
		else $error("Serial ALU started while an operation was still running.");

endmodule

// File: src/edf_rank_unit.sv
// Digit-serial ranking of one task's next deadline against all active tasks.
`timescale 1ns / 1ps

module edf_rank_unit #(
	parameter int MAX_TASKS  = edf_pkg::EDF_MAX_TASKS,
	parameter int TIME_WIDTH = edf_pkg::EDF_TIME_W,
	localparam int IDX_W     = $clog2(MAX_TASKS),
	localparam int CNT_W     = $clog2(MAX_TASKS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [IDX_W-1:0]      tgt,
	input  logic [CNT_W-1:0]      n,
	input  logic [TIME_WIDTH-1:0] nd [MAX_TASKS],
	output logic                  done,
	output logic [CNT_W-1:0]      prio
);
	import edf_pkg::*;

	localparam int D     = EDF_DIGIT_W;
	localparam int NDIG  = (TIME_WIDTH + EDF_DIGIT_W - 1) / EDF_DIGIT_W;
	localparam int PW    = NDIG * EDF_DIGIT_W;
	localparam int DIG_W = $clog2(NDIG);

	logic [PW-1:0]        cmp_q [MAX_TASKS];
	logic [MAX_TASKS-1:0] gt_q;
	logic [MAX_TASKS-1:0] eq_q;
	logic [MAX_TASKS-1:0] ahead;
	logic [IDX_W-1:0]     tgt_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     prio_q;
	logic [CNT_W-1:0]     ahead_cnt;
	logic [DIG_W-1:0]     cnt_q;
	logic                 run_q;
	logic                 sum_q;
	logic                 done_q;
	logic [D-1:0]         tgt_dig;

	assign tgt_dig = cmp_q[tgt_q][PW-1 -: D];
	assign done    = done_q;
	assign prio    = prio_q;

	// A task is ahead when its deadline is later, or equal with a lower index.
	always_comb begin
		ahead_cnt = '0;
		for (int u = 0; u < MAX_TASKS; u++) begin
			ahead[u] = (CNT_W'(u) < n_q) &&
				(gt_q[u] || (eq_q[u] && (IDX_W'(u) < tgt_q)));
			ahead_cnt = ahead_cnt + CNT_W'(ahead[u]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			sum_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			sum_q  <= 1'b0;
			done_q <= sum_q;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIG_W'(1);
				if (cnt_q == DIG_W'(NDIG - 1)) begin
					run_q <= 1'b0;
					sum_q <= 1'b1;
				end
			end
		end
	end

	// Each lane rotates its copy so that the most significant digit comes first.
	always_ff @(posedge clk) begin
		if (go) begin
			tgt_q <= tgt;
			n_q   <= n;
			gt_q  <= '0;
			eq_q  <= '1;
			for (int u = 0; u < MAX_TASKS; u++) begin
				cmp_q[u] <= PW'(nd[u]);
			end
		end else if (run_q) begin
			for (int u = 0; u < MAX_TASKS; u++) begin
				cmp_q[u] <= {cmp_q[u][PW-D-1:0], cmp_q[u][PW-1 -: D]};
				if (eq_q[u]) begin
					gt_q[u] <= cmp_q[u][PW-1 -: D] > tgt_dig;
					eq_q[u] <= cmp_q[u][PW-1 -: D] == tgt_dig;
				end
			end
		end
		if (sum_q) begin
			prio_q <= ahead_cnt + CNT_W'(1);
		end
	end

	a_prio_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (prio_q != '0) && (prio_q <= n_q))
		else $error("Rank outside the range of active tasks.");

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !run_q && !sum_q)
		else $error("Rank unit started while a comparison was in progress.");

endmodule

// File: src/edf_priority_assigner_unit.sv
// Top level of the earliest-deadline-first task table and priority assigner.
//
//   Channel  Role    Transfer
//   req      sink    one event: define, start or job end
//   res      source  one priority per active task, last marks the end of a run
//
// A define, like an ignored event, is handled in the idle state.
// A job end computes slack and the next deadline, a start the next deadline of each task,
// on the shared digit-serial adder in NDIG = ceil(TIME_WIDTH / 8) digits; then the shared
// rank unit ranks each of the n defined tasks in turn.
// Reset clears the task count and all control state; no clearing pass is needed.
// A stalled result transfer holds the sequencer in its output state.
`timescale 1ns / 1ps

module edf_priority_assigner_unit #(
	parameter int MAX_TASKS  = edf_pkg::EDF_MAX_TASKS,
	parameter int TIME_WIDTH = edf_pkg::EDF_TIME_W
) (
	input  logic     clk,
	input  logic     arst_n,
	edf_req_if.sink  req,
	edf_res_if.source res
);
	import edf_pkg::*;

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int TW    = TIME_WIDTH;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ST_GO   = 4'd1;
	localparam logic [3:0] S_ST_WAIT = 4'd2;
	localparam logic [3:0] S_JS_GO   = 4'd3;
	localparam logic [3:0] S_JS_WAIT = 4'd4;
	localparam logic [3:0] S_JA_GO   = 4'd5;
	localparam logic [3:0] S_JA_WAIT = 4'd6;
	localparam logic [3:0] S_RK_GO   = 4'd7;
	localparam logic [3:0] S_RK_WAIT = 4'd8;
	localparam logic [3:0] S_OUT     = 4'd9;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TW-1:0]     now_q;
	logic [SLACK_W-1:0] slack_q;
	logic              missed_q;
	logic [MISS_W-1:0] mtot_q;
	logic [TW-1:0]     per_q [MAX_TASKS];
	logic [TW-1:0]     nd_q [MAX_TASKS];
	logic [MISS_W-1:0] miss_q [MAX_TASKS];
	edf_res_t          res_q;
	logic              res_valid_q;

	logic              req_fire;
	logic [TW+31:0]    now_ext;
	logic [TW+31:0]    per_ext;
	logic [TW-1:0]     now_tw;
	logic [TW-1:0]     per_tw;
	logic [CNT_W+2:0]  sel_ext;
	logic [CNT_W+2:0]  cnt_ext;
	logic              sel_ok;
	logic              table_full;
	logic [IDX_W-1:0]  cnt_idx;
	logic              last_task;
	logic              out_free;
	logic [IDX_W+2:0]  tid_ext;

	edf_alu_cmd_t      alu_cmd;
	logic [TW-1:0]     alu_a;
	logic [TW-1:0]     alu_b;
	logic              alu_done;
	logic [TW-1:0]     alu_sum;
	logic              alu_carry;
	logic              alu_miss;
	logic [MISS_W-1:0] mtot_next;
	logic [SLACK_W-1:0] slack_sat;

	logic              rank_go;
	logic              rank_done;
	logic [CNT_W-1:0]  rank_prio;
	logic [CNT_W+3:0]  prio_ext;

	assign req_fire   = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign now_ext    = {{TW{1'b0}}, req.payload.now_ticks};
	assign per_ext    = {{TW{1'b0}}, req.payload.period_ticks};
	assign now_tw     = now_ext[TW-1:0];
	assign per_tw     = per_ext[TW-1:0];
	assign sel_ext    = {{CNT_W{1'b0}}, req.payload.task_sel};
	assign cnt_ext    = {3'b000, count_q};
	assign sel_ok     = sel_ext < cnt_ext;
	assign table_full = (count_q >= CNT_W'(MAX_TASKS));
	assign cnt_idx    = count_q[IDX_W-1:0];
	assign last_task  = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign out_free   = !res_valid_q || res.ready;
	assign tid_ext    = {3'b000, idx_q};
	assign prio_ext   = {4'b0000, rank_prio};
	assign rank_go    = (state_q == S_RK_GO);

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	// The job is late when now is at or past the deadline: no borrow means deadline >= now.
	assign alu_miss  = !alu_carry || (alu_sum == '0);
	assign mtot_next = (alu_miss && (miss_q[idx_q] != MISS_MAX)) ?
		miss_q[idx_q] + MISS_W'(1) : miss_q[idx_q];

	if (TW > SLACK_W) begin : g_sat
		always_comb begin
			if ((&alu_sum[TW-1:SLACK_W-1]) || !(|alu_sum[TW-1:SLACK_W-1])) begin
				slack_sat = alu_sum[SLACK_W-1:0];
			end else if (alu_sum[TW-1]) begin
				slack_sat = {1'b1, {(SLACK_W-1){1'b0}}};
			end else begin
				slack_sat = {1'b0, {(SLACK_W-1){1'b1}}};
			end
		end
	end else begin : g_ext
		logic [2*SLACK_W-1:0] sx;
		assign sx        = {{(2*SLACK_W-TW){alu_sum[TW-1]}}, alu_sum};
		assign slack_sat = sx[SLACK_W-1:0];
	end

	always_comb begin
		alu_cmd = '0;
		alu_a   = nd_q[idx_q];
		alu_b   = per_q[idx_q];
		unique case (state_q)
			S_ST_GO: begin
				alu_cmd.go = 1'b1;
				alu_a      = now_q;
			end
			S_JS_GO: begin
				alu_cmd.go  = 1'b1;
				alu_cmd.sub = 1'b1;
				alu_b       = now_q;
			end
			S_JA_GO: begin
				alu_cmd.go = 1'b1;
			end
			default: begin
			end
		endcase
	end

	edf_serial_alu #(
		.TIME_WIDTH (TW)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.a      (alu_a),
		.b      (alu_b),
		.done   (alu_done),
		.sum    (alu_sum),
		.carry  (alu_carry)
	);

	edf_rank_unit #(
		.MAX_TASKS  (MAX_TASKS),
		.TIME_WIDTH (TW)
	) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (rank_go),
		.tgt    (idx_q),
		.n      (count_q),
		.nd     (nd_q),
		.done   (rank_done),
		.prio   (rank_prio)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						unique case (req.payload.opcode)
							OP_DEFINE: begin
								if (!table_full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_START: begin
								if (count_q != '0) begin
									idx_q   <= '0;
									state_q <= S_ST_GO;
								end
							end
							OP_JOB_END: begin
								if (sel_ok) begin
									idx_q   <= sel_ext[IDX_W-1:0];
									state_q <= S_JS_GO;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ST_GO: state_q <= S_ST_WAIT;
				S_ST_WAIT: begin
					if (alu_done) begin
						if (last_task) begin
							idx_q   <= '0;
							state_q <= S_RK_GO;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_ST_GO;
						end
					end
				end
				S_JS_GO: state_q <= S_JS_WAIT;
				S_JS_WAIT: begin
					if (alu_done) begin
						state_q <= S_JA_GO;
					end
				end
				S_JA_GO: state_q <= S_JA_WAIT;
				S_JA_WAIT: begin
					if (alu_done) begin
						idx_q   <= '0;
						state_q <= S_RK_GO;
					end
				end
				S_RK_GO: state_q <= S_RK_WAIT;
				S_RK_WAIT: begin
					if (rank_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (last_task) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_RK_GO;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The table holds next deadlines; a new task's last deadline is zero.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			now_q <= now_tw;
		end
		if (req_fire && req.payload.opcode == OP_DEFINE && !table_full) begin
			per_q[cnt_idx]  <= per_tw;
			nd_q[cnt_idx]   <= per_tw;
			miss_q[cnt_idx] <= '0;
		end
		if (req_fire && req.payload.opcode == OP_START) begin
			slack_q  <= '0;
			missed_q <= 1'b0;
			mtot_q   <= '0;
		end
		if ((state_q == S_ST_WAIT || state_q == S_JA_WAIT) && alu_done) begin
			nd_q[idx_q] <= alu_sum;
		end
		if (state_q == S_JS_WAIT && alu_done) begin
			slack_q       <= slack_sat;
			missed_q      <= alu_miss;
			mtot_q        <= mtot_next;
			miss_q[idx_q] <= mtot_next;
		end
		if (state_q == S_OUT && out_free) begin
			res_q.task_id    <= tid_ext[TASK_W-1:0];
			res_q.prio       <= prio_ext[PRIO_W-1:0];
			res_q.slack      <= slack_q;
			res_q.missed     <= missed_q;
			res_q.miss_total <= mtot_q;
			res_q.last       <= last_task;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TASKS))
		else $error("Task count beyond the size of the table.");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free && last_task) |=>
			(state_q == S_IDLE) && res_valid_q && res_q.last)
		else $error("Final result of a run not followed by return to idle.");

endmodule
